### sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // width of the per-string output byte counter
    localparam int CNT_W = 16;

    typedef logic [2:0]       t_phase;
    typedef logic [2:0]       t_status;
    typedef logic [CNT_W-1:0] t_count;

    localparam t_phase PH_TEXT    = 3'd0;
    localparam t_phase PH_ESC     = 3'd1;
    localparam t_phase PH_HEX0    = 3'd2;
    localparam t_phase PH_HEX1    = 3'd3;
    localparam t_phase PH_HEX2    = 3'd4;
    localparam t_phase PH_HEX3    = 3'd5;
    localparam t_phase PH_WANT_BS = 3'd6;
    localparam t_phase PH_WANT_U  = 3'd7;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BAD_ESC  = 3'd1;
    localparam t_status ST_BAD_HEX  = 3'd2;
    localparam t_status ST_BAD_SURR = 3'd3;
    localparam t_status ST_OVERFLOW = 3'd4;
    localparam t_status ST_TRUNC    = 3'd5;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] accum;
        logic [9:0]  high_part;
        logic        need_low;
        t_count      written;
        t_status     err;
    } t_state;

    // results caused by one input item: up to four data bytes and a completion
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      cnt;
        logic            has_end;
        t_status         status;
    } t_bundle;

endpackage

### sv/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if
// Channel interfaces: raw byte input, decoded byte output, config write.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;
    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_end;
    logic [2:0] status;
    modport source (output valid, output out_byte, output is_end, output status, input ready);
    modport sink   (input valid, input out_byte, input is_end, input status, output ready);
endinterface

interface jsu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Combinational step: one raw byte against the string state gives the next
// state and the bundle of results for that byte.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  jsu_pkg::t_count  i_limit,
    output jsu_pkg::t_state  o_state,
    output jsu_pkg::t_bundle o_bundle
);
    import jsu_pkg::*;

    t_state      s;
    t_state      s_fin;
    logic [3:0]  digit;
    logic        digit_ok;
    logic [15:0] v;
    logic [20:0] cp;
    logic        do_code;
    logic [2:0]  len;
    logic [3:0][7:0] enc;
    logic [2:0]  cnt;
    logic [2:0]  cnt_fin;
    logic [3:0][7:0] data;
    logic [3:0][7:0] data_fin;
    logic [CNT_W:0] need;
    t_status     st;

    always_comb begin
        digit    = 4'd0;
        digit_ok = 1'b1;
        if (i_byte inside {[8'h61:8'h66]}) begin
            digit = 4'(i_byte - 8'h57);
        end else if (i_byte inside {[8'h41:8'h46]}) begin
            digit = 4'(i_byte - 8'h37);
        end else if (i_byte inside {[8'h30:8'h39]}) begin
            digit = 4'(i_byte - 8'h30);
        end else begin
            digit_ok = 1'b0;
        end
    end

    assign v = {i_state.accum[11:0], digit};

    always_comb begin
        s       = i_state;
        cnt     = 3'd0;
        data    = '0;
        cp      = 21'd0;
        do_code = 1'b0;
        if (i_state.err == ST_OK) begin
            if (i_state.written >= i_limit) begin
                s.err = ST_OVERFLOW;
            end else begin
                case (i_state.phase)
                    PH_TEXT: begin
                        if (i_byte == 8'h5C) begin
                            s.phase = PH_ESC;
                        end else begin
                            cnt     = 3'd1;
                            data[0] = i_byte;
                        end
                    end
                    PH_ESC: begin
                        s.phase = PH_TEXT;
                        cnt     = 3'd1;
                        case (i_byte)
                            8'h75: begin
                                s.phase = PH_HEX0;
                                s.accum = '0;
                                cnt     = 3'd0;
                            end
                            8'h6E:   data[0] = 8'h0A;
                            8'h22:   data[0] = 8'h22;
                            8'h5C:   data[0] = 8'h5C;
                            8'h74:   data[0] = 8'h09;
                            8'h2F:   data[0] = 8'h2F;
                            8'h72:   data[0] = 8'h0D;
                            8'h62:   data[0] = 8'h08;
                            8'h66:   data[0] = 8'h0C;
                            default: begin
                                s.err = ST_BAD_ESC;
                                cnt   = 3'd0;
                            end
                        endcase
                    end
                    PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
                        if (!digit_ok) begin
                            s.err = ST_BAD_HEX;
                        end else if (i_state.phase != PH_HEX3) begin
                            s.accum = v;
                            s.phase = i_state.phase + 3'd1;
                        end else begin
                            s.accum = '0;
                            s.phase = PH_TEXT;
                            if (!i_state.need_low) begin
                                if (v inside {[16'hDC00:16'hDFFF]}) begin
                                    s.err = ST_BAD_SURR;
                                end else if (v inside {[16'hD800:16'hDBFF]}) begin
                                    s.high_part = v[9:0];
                                    s.need_low  = 1'b1;
                                    s.phase     = PH_WANT_BS;
                                end else begin
                                    cp      = 21'(v);
                                    do_code = 1'b1;
                                end
                            end else begin
                                if (!(v inside {[16'hDC00:16'hDFFF]})) begin
                                    s.err = ST_BAD_SURR;
                                end else begin
                                    s.need_low = 1'b0;
                                    cp      = {1'b0, i_state.high_part, v[9:0]} + 21'h10000;
                                    do_code = 1'b1;
                                end
                            end
                        end
                    end
                    PH_WANT_BS: begin
                        if (i_byte == 8'h5C) s.phase = PH_WANT_U;
                        else s.err = ST_BAD_SURR;
                    end
                    PH_WANT_U: begin
                        if (i_byte == 8'h75) begin
                            s.phase = PH_HEX0;
                            s.accum = '0;
                        end else begin
                            s.err = ST_BAD_SURR;
                        end
                    end
                    default: s.phase = PH_TEXT;
                endcase
            end
        end
    end

    // utf-8 encoding of the finished code point
    logic [20:0] cpx;
    assign cpx = (cp > 21'h10FFFF) ? 21'h00FFFD : cp;

    always_comb begin
        enc = '0;
        if (cpx < 21'h80) begin
            len    = 3'd1;
            enc[0] = cpx[7:0];
        end else if (cpx < 21'h800) begin
            len    = 3'd2;
            enc[0] = {3'b110, cpx[10:6]};
            enc[1] = {2'b10, cpx[5:0]};
        end else if (cpx < 21'h10000) begin
            len    = 3'd3;
            enc[0] = {4'b1110, cpx[15:12]};
            enc[1] = {2'b10, cpx[11:6]};
            enc[2] = {2'b10, cpx[5:0]};
        end else begin
            len    = 3'd4;
            enc[0] = {5'b11110, cpx[20:18]};
            enc[1] = {2'b10, cpx[17:12]};
            enc[2] = {2'b10, cpx[11:6]};
            enc[3] = {2'b10, cpx[5:0]};
        end
    end

    assign need = {1'b0, i_state.written} + (CNT_W+1)'(len);

    // a character is written whole or not at all
    always_comb begin
        s_fin    = s;
        cnt_fin  = cnt;
        data_fin = data;
        if (do_code) begin
            if (need > {1'b0, i_limit}) begin
                s_fin.err = ST_OVERFLOW;
            end else begin
                cnt_fin  = len;
                data_fin = enc;
            end
        end
        s_fin.written = i_state.written + CNT_W'(cnt_fin);
    end

    always_comb begin
        if (s_fin.err != ST_OK)          st = s_fin.err;
        else if (s_fin.need_low)         st = ST_BAD_SURR;
        else if (s_fin.phase != PH_TEXT) st = ST_TRUNC;
        else                             st = ST_OK;
    end

    always_comb begin
        o_bundle.data    = data_fin;
        o_bundle.cnt     = cnt_fin;
        o_bundle.has_end = i_last;
        o_bundle.status  = st;
        o_state          = i_last ? '0 : s_fin;
    end

endmodule

### sv/jsu_drain.sv
// ----------------------------------------------------------------------------
// jsu_drain
// Result register: holds one bundle and hands its items out one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module jsu_drain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jsu_pkg::t_bundle  i_bundle,
    output logic              o_can_load,
    jsu_out_if.source         o_out
);
    import jsu_pkg::*;

    t_bundle    r_bundle;
    logic       r_busy;
    logic [2:0] r_idx;
    logic [2:0] total;
    logic       take;
    logic       last_take;
    logic       on_data;

    assign total     = r_bundle.cnt + 3'(r_bundle.has_end);
    assign take      = r_busy && o_out.ready;
    assign last_take = take && (r_idx == total - 3'd1);
    assign o_can_load = !r_busy || last_take;
    assign on_data   = r_idx < r_bundle.cnt;

    assign o_out.valid    = r_busy;
    assign o_out.out_byte = on_data ? r_bundle.data[r_idx[1:0]] : 8'h00;
    assign o_out.is_end   = !on_data;
    assign o_out.status   = on_data ? ST_OK : r_bundle.status;

    // an item with no results leaves the register empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (i_load && (i_bundle.cnt != 3'd0 || i_bundle.has_end)) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (last_take) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

### sv/json_string_unescape_utf8_top.sv
// Latency: an item's first result is shown the cycle after it is accepted.
// Throughput: one byte per cycle; a byte that decodes to more than one result
// holds the input as the result register drains, one item per cycle if ready.
// Reset: synchronous active low; clears the string state and the result
// register, and sets buffer_size to 256 (output limit 255).
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with UTF-8 output and a completion item per
// string.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out,
    jsu_cfg_if.sink   i_cfg
);
    import jsu_pkg::*;

    localparam logic [32:0] CNT_MAX = (33'd1 << CNT_W) - 33'd1;

    function automatic t_count limit_of(input logic [15:0] size);
        logic [32:0] lim;
        lim = (size >= 16'd2) ? 33'(size - 16'd1) : 33'd0;
        return (lim < CNT_MAX) ? lim[CNT_W-1:0] : CNT_MAX[CNT_W-1:0];
    endfunction

    t_state  r_state;
    t_state  n_state;
    t_count  r_limit;
    t_bundle bundle;
    logic    can_load;
    logic    accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = can_load;
    assign accept      = i_in.valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= limit_of(16'd256);
        end else if (i_cfg.valid) begin
            r_limit <= limit_of(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    jsu_decode u_decode (
        .i_state  (r_state),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.last_byte),
        .i_limit  (r_limit),
        .o_state  (n_state),
        .o_bundle (bundle)
    );

    jsu_drain u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // a final byte leaves a clean string state
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_byte |=> r_state == '0)
        else $error("string state not cleared after final byte");

    // once in error, a non-final byte gives nothing
    a_sticky_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_in.last_byte && r_state.err != ST_OK |=> !o_out.valid)
        else $error("result produced after sticky error");

    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_end |-> o_out.status <= ST_TRUNC && o_out.out_byte == 8'h00)
        else $error("bad completion item");

endmodule
